/* sv/lph_pkg.sv */
// Package: shared constants and item types for the linear probe hash map.
package lph_pkg;
   localparam int TABLE_DEPTH  = 1024;
   localparam int PAYLOAD_BITS = 32;
   localparam int AW           = $clog2(TABLE_DEPTH);
   localparam int KEY_BITS     = 64;
   localparam int HASH_BITS    = 32;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_FIND   = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DUP      = 2'd1;
   localparam logic [1:0] ST_MISS     = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic [1:0] REG_SIZE  = 2'd0;
   localparam logic [1:0] REG_LIMIT = 2'd1;

   localparam logic [10:0] SIZE_RESET  = 11'd1024;
   localparam logic [9:0]  LIMIT_RESET = 10'd96;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] lookup_key;
      logic [31:0] payload;
   } lph_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [9:0]  slot;
      logic [31:0] found_payload;
      logic [9:0]  worst_run;
      logic        over_limit;
      logic [10:0] entry_count;
   } lph_rsp_type;
endpackage

/* sv/lph_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module lph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* sv/linear_probe_hash_map.sv */
// Top level: open-addressing hash map with linear probing over block RAMs.
// Insert/find work out the home bucket by restoring modulo (one bit a cycle), then read and
// test each probed bucket, update the home bucket's longest search when it grows and issue the
// result; find on an empty table and the unused command go straight to the result, clear clears.
// One item is in flight at a time. Reset (synchronous) starts a clearing pass with no item
// accepted; configuration writes are taken in every state, but are lost while reset is held.
module linear_probe_hash_map (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lph_pkg::lph_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lph_pkg::lph_rsp_type rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [10:0]         csr_data
);
   import lph_pkg::*;

   localparam int MW = 1 + AW;
   localparam int KW = KEY_BITS + PAYLOAD_BITS;

   typedef enum logic [2:0] {
      S_CLR, S_IDLE, S_DIV, S_RD, S_EV, S_HOME, S_DONE
   } state_type;

   state_type         state_ff;
   logic [10:0]       size_ff;
   logic [9:0]        limit_ff;
   logic [1:0]        cmd_ff;
   logic [63:0]       key_ff;
   logic [PAYLOAD_BITS-1:0] pay_ff;
   logic [AW:0]       rem_ff;
   logic [HASH_BITS-1:0] quo_ff;
   logic [4:0]        div_cnt_ff;
   logic [AW-1:0]     home_ff;
   logic [AW-1:0]     idx_ff;
   logic [AW-1:0]     d_ff;
   logic [AW-1:0]     home_long_ff;
   logic [AW-1:0]     limit_d_ff;
   logic [AW:0]       clr_cnt_ff;
   logic              clr_cmd_ff;
   logic [AW-1:0]     worst_ff;
   logic [AW:0]       count_ff;
   logic [1:0]        res_status_ff;
   logic [AW-1:0]     res_slot_ff;
   logic [31:0]       res_found_ff;
   logic              rsp_valid_ff;
   lph_rsp_type       rsp_ff;

   logic [AW:0]       eff_size;
   logic [AW+1:0]     div_sh;
   logic [AW:0]       rem_next;
   logic [AW-1:0]     idx_next;
   logic [AW:0]       n_cap;
   logic              meta_we, kv_we;
   logic [AW-1:0]     meta_waddr;
   logic [MW-1:0]     meta_wdata, meta_rdata;
   logic [KW-1:0]     kv_rdata;
   logic              rd_live;
   logic [AW-1:0]     rd_long;
   logic              key_hit;

   always_comb begin
      if (size_ff == 11'd0) begin
         eff_size = (AW+1)'(1);
      end else if (32'(size_ff) > TABLE_DEPTH) begin
         eff_size = (AW+1)'(TABLE_DEPTH);
      end else begin
         eff_size = (AW+1)'(size_ff);
      end
   end

   assign div_sh   = {rem_ff, quo_ff[HASH_BITS-1]};
   assign rem_next = (div_sh >= (AW+2)'(eff_size)) ? (AW+1)'(div_sh - (AW+2)'(eff_size))
                                                   : div_sh[AW:0];
   assign idx_next = ((AW+1)'(idx_ff) + 1'b1 == eff_size) ? '0 : idx_ff + 1'b1;
   assign rd_live  = meta_rdata[MW-1];
   assign rd_long  = meta_rdata[AW-1:0];
   assign key_hit  = kv_rdata[KW-1:PAYLOAD_BITS] == key_ff;
   // cap the search to one full turn of the table
   assign n_cap    = ((AW+1)'(rd_long) >= eff_size) ? eff_size - 1'b1 : (AW+1)'(rd_long);

   always_comb begin
      meta_we    = 1'b0;
      meta_waddr = idx_ff;
      meta_wdata = {1'b1, rd_long};
      kv_we      = 1'b0;
      unique case (state_ff)
         S_CLR: begin
            meta_we    = clr_cnt_ff != (AW+1)'(TABLE_DEPTH);
            meta_waddr = clr_cnt_ff[AW-1:0];
            meta_wdata = '0;
         end
         S_EV: begin
            if (cmd_ff == CMD_INSERT && !rd_live) begin
               meta_we = 1'b1;
               kv_we   = 1'b1;
            end
         end
         S_HOME: begin
            meta_we    = 1'b1;
            meta_waddr = home_ff;
            meta_wdata = {1'b1, res_slot_ff == home_ff ? home_long_ff : limit_d_ff};
         end
         default: ;
      endcase
   end

   lph_ram #(.WIDTH(MW), .DEPTH(TABLE_DEPTH)) u_meta (
      .clock(clock), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
      .raddr(idx_ff), .rdata(meta_rdata)
   );

   lph_ram #(.WIDTH(KW), .DEPTH(TABLE_DEPTH)) u_kv (
      .clock(clock), .we(kv_we), .waddr(idx_ff), .wdata({key_ff, pay_ff}),
      .raddr(idx_ff), .rdata(kv_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         size_ff      <= SIZE_RESET;
         limit_ff     <= LIMIT_RESET;
         clr_cnt_ff   <= '0;
         clr_cmd_ff   <= 1'b0;
         worst_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               REG_SIZE:  size_ff  <= csr_data;
               REG_LIMIT: limit_ff <= csr_data[9:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLR: begin
               if (clr_cnt_ff == (AW+1)'(TABLE_DEPTH)) begin
                  state_ff <= clr_cmd_ff ? S_DONE : S_IDLE;
               end else begin
                  clr_cnt_ff <= clr_cnt_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff        <= req_data.command;
                  key_ff        <= req_data.lookup_key;
                  pay_ff        <= req_data.payload[PAYLOAD_BITS-1:0];
                  quo_ff        <= req_data.lookup_key[HASH_BITS-1:0];
                  rem_ff        <= '0;
                  div_cnt_ff    <= '0;
                  res_status_ff <= ST_OK;
                  res_slot_ff   <= '0;
                  res_found_ff  <= '0;
                  unique case (req_data.command)
                     CMD_INSERT: state_ff <= S_DIV;
                     CMD_FIND: begin
                        if (count_ff == '0) begin
                           res_status_ff <= ST_MISS;
                           state_ff      <= S_DONE;
                        end else begin
                           state_ff <= S_DIV;
                        end
                     end
                     CMD_CLEAR: begin
                        worst_ff   <= '0;
                        count_ff   <= '0;
                        clr_cnt_ff <= '0;
                        clr_cmd_ff <= 1'b1;
                        state_ff   <= S_CLR;
                     end
                     default: state_ff <= S_DONE;
                  endcase
               end
            end
            S_DIV: begin
               // restoring division, one quotient bit a cycle
               rem_ff     <= rem_next;
               quo_ff     <= quo_ff << 1;
               div_cnt_ff <= div_cnt_ff + 1'b1;
               d_ff       <= '0;
               if (div_cnt_ff == 5'd31) begin
                  // start the first read at the home bucket
                  home_ff  <= rem_next[AW-1:0];
                  idx_ff   <= rem_next[AW-1:0];
                  state_ff <= S_RD;
               end
            end
            S_RD: begin
               state_ff <= S_EV;
            end
            S_EV: begin
               if (d_ff == '0) begin
                  home_long_ff <= rd_long;
                  limit_d_ff   <= n_cap[AW-1:0];
               end
               state_ff <= S_RD;
               idx_ff   <= idx_next;
               d_ff     <= d_ff + 1'b1;
               if (cmd_ff == CMD_INSERT) begin
                  if (!rd_live) begin
                     res_slot_ff <= idx_ff;
                     count_ff    <= count_ff + 1'b1;
                     if (d_ff > worst_ff) begin
                        worst_ff <= d_ff;
                     end
                     limit_d_ff <= d_ff;
                     state_ff   <= (d_ff != '0 && d_ff > home_long_ff) ? S_HOME : S_DONE;
                  end else if (key_hit) begin
                     res_status_ff <= ST_DUP;
                     res_slot_ff   <= idx_ff;
                     state_ff      <= S_DONE;
                  end else if ((AW+1)'(d_ff) == eff_size - 1'b1) begin
                     res_status_ff <= ST_FULL;
                     state_ff      <= S_DONE;
                  end
               end else begin
                  if (rd_live && key_hit) begin
                     res_slot_ff  <= idx_ff;
                     res_found_ff <= 32'(kv_rdata[PAYLOAD_BITS-1:0]);
                     state_ff     <= S_DONE;
                  end else if (d_ff == (d_ff == '0 ? n_cap[AW-1:0] : limit_d_ff)) begin
                     res_status_ff <= ST_MISS;
                     state_ff      <= S_DONE;
                  end
               end
            end
            S_HOME: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_ff.status        <= res_status_ff;
                  rsp_ff.slot          <= 10'(res_slot_ff);
                  rsp_ff.found_payload <= res_found_ff;
                  rsp_ff.worst_run     <= 10'(worst_ff);
                  rsp_ff.over_limit    <= 32'(worst_ff) > 32'(limit_ff);
                  rsp_ff.entry_count   <= 11'(count_ff);
                  clr_cmd_ff           <= 1'b0;
                  state_ff             <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != S_IDLE)
      else $error("accepted item did not start");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= TABLE_DEPTH)
      else $error("live count beyond table depth");
   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EV |-> ((AW+1)'(d_ff) < eff_size && (AW+1)'(idx_ff) < eff_size))
      else $error("probe outside the buckets in use");
   a_over_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.over_limit == (rsp_data.worst_run > limit_ff))
      else $error("over limit flag inconsistent");
endmodule

/* tb/tb_linear_probe_hash_map.sv */
// Testbench for the linear probe hash map: shadow table, random traffic, in-order checks.
module tb_linear_probe_hash_map;
   timeunit 1ns;
   timeprecision 1ps;
   import lph_pkg::*;

   class lph_table_board;
      logic [63:0] key_shadow [TABLE_DEPTH];
      logic [31:0] pay_shadow [TABLE_DEPTH];
      bit          live_shadow [TABLE_DEPTH];
      int unsigned search_shadow [TABLE_DEPTH];
      int unsigned live_total;
      int unsigned worst_total;
      int unsigned size_reg;
      int unsigned limit_reg;
      lph_rsp_type pending [$];
      int unsigned mismatches;

      function void wipe();
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            live_shadow[i] = 0;
            search_shadow[i] = 0;
         end
         live_total = 0;
         worst_total = 0;
      endfunction

      function new();
         wipe();
         size_reg = 32'(SIZE_RESET);
         limit_reg = 32'(LIMIT_RESET);
         mismatches = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [10:0] val);
         if (idx == REG_SIZE) size_reg = 32'(val);
         else if (idx == REG_LIMIT) limit_reg = 32'(val[9:0]);
      endfunction

      function int unsigned active_size();
         int unsigned s;
         s = size_reg;
         if (s == 0) s = 1;
         if (s > TABLE_DEPTH) s = TABLE_DEPTH;
         return s;
      endfunction

      // compute the response for one accepted item and queue it
      function void note_request(lph_req_type r);
         lph_rsp_type e;
         int unsigned s, home, idx, n;
         s = active_size();
         home = r.lookup_key[31:0] % s;
         e = '0;
         if (r.command == CMD_INSERT) begin
            e.status = ST_FULL;
            for (int unsigned d = 0; d < s; d++) begin
               idx = (home + d) % s;
               if (!live_shadow[idx]) begin
                  key_shadow[idx] = r.lookup_key;
                  pay_shadow[idx] = r.payload;
                  live_shadow[idx] = 1;
                  if (search_shadow[home] < d) search_shadow[home] = d;
                  if (worst_total < d) worst_total = d;
                  live_total++;
                  e.status = ST_OK;
                  e.slot = 10'(idx);
                  break;
               end
               if (key_shadow[idx] == r.lookup_key) begin
                  e.status = ST_DUP;
                  e.slot = 10'(idx);
                  break;
               end
            end
         end else if (r.command == CMD_FIND) begin
            e.status = ST_MISS;
            if (live_total != 0) begin
               n = search_shadow[home];
               if (n >= s) n = s - 1;
               for (int unsigned d = 0; d <= n; d++) begin
                  idx = (home + d) % s;
                  if (live_shadow[idx] && key_shadow[idx] == r.lookup_key) begin
                     e.status = ST_OK;
                     e.slot = 10'(idx);
                     e.found_payload = pay_shadow[idx];
                     break;
                  end
               end
            end
         end else if (r.command == CMD_CLEAR) begin
            wipe();
         end
         e.worst_run = 10'(worst_total);
         e.over_limit = worst_total > limit_reg;
         e.entry_count = 11'(live_total);
         pending.push_back(e);
      endfunction

      function void check_response(lph_rsp_type got);
         lph_rsp_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
            return;
         end
         e = pending.pop_front();
         if (got !== e) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, got);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   lph_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   lph_rsp_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [10:0] csr_data = '0;

   lph_table_board board = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_rsp = 0;
   longint cycles = 0;

   linear_probe_hash_map dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 20000000) begin
         $display("linear_probe_hash_map verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);
   end

   // receiver stall, updated on the falling edge
   always @(negedge clock) begin
      if (hold_rsp) rsp_stall <= 1;
      else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   task automatic write_csr(logic [1:0] idx, logic [10:0] val);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic send_item(logic [1:0] cmd, logic [63:0] key, logic [31:0] pay);
      lph_req_type r;
      r.command = cmd;
      r.lookup_key = key;
      r.payload = pay;
      do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      board.note_request(r);
      @(negedge clock);
      req_valid <= 0;
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
   endtask

   // keys drawn from a small pool so duplicates and hits are common
   function automatic logic [63:0] pick_key(int pool);
      logic [63:0] k;
      int unsigned v;
      v = $urandom_range(pool);
      if ($urandom_range(9) == 0) k = {$urandom, $urandom};
      else k = {1'($urandom_range(1)), 23'h0, v[7:0], v};
      return k;
   endfunction

   task automatic random_phase(int count, int pool);
      logic [1:0] cmd;
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 50) cmd = CMD_INSERT;
         else if (r < 97) cmd = CMD_FIND;
         else if (r < 99) cmd = CMD_CLEAR;
         else cmd = CMD_UNUSED;
         send_item(cmd, pick_key(pool), $urandom);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      write_csr(REG_SIZE, 11'd8);
      write_csr(REG_LIMIT, 10'd0);
      // directed: extremes, duplicate, full table, miss, clear, unused command
      send_item(CMD_FIND, 64'h0, 32'h0);
      send_item(CMD_INSERT, 64'h0, 32'hFFFF_FFFF);
      send_item(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
      send_item(CMD_INSERT, 64'h0, 32'h1234_5678);
      for (int i = 0; i < 7; i++) send_item(CMD_INSERT, 64'(i * 8 + 16), 32'(i));
      send_item(CMD_INSERT, 64'h1_0000_0010, 32'hA5A5_A5A5);
      send_item(CMD_FIND, 64'h0, 32'h0);
      send_item(CMD_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
      send_item(CMD_FIND, 64'h40, 32'h0);
      send_item(CMD_FIND, 64'h1234, 32'h0);
      send_item(CMD_UNUSED, 64'h5, 32'h5);
      drain();
      write_csr(REG_SIZE, 11'd4);
      send_item(CMD_FIND, 64'h40, 32'h0);
      send_item(CMD_INSERT, 64'h99, 32'h9);
      send_item(CMD_CLEAR, 64'h0, 32'h0);
      send_item(CMD_FIND, 64'h0, 32'h0);
      drain();
      write_csr(REG_SIZE, 11'd0);
      send_item(CMD_INSERT, 64'h7, 32'h7);
      send_item(CMD_INSERT, 64'h8, 32'h8);
      send_item(CMD_FIND, 64'h7, 32'h0);
      drain();
      write_csr(REG_SIZE, 11'd2047);
      write_csr(REG_LIMIT, 10'd1023);
      send_item(CMD_CLEAR, 64'h0, 32'h0);
      send_item(CMD_INSERT, 64'h3FF, 32'h1);
      send_item(CMD_INSERT, 64'h7FF, 32'h2);
      drain();

      // long receiver hold while the sender keeps offering items
      fork
         begin
            hold_rsp = 1;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
         random_phase(20, 300);
      join
      drain();

      send_idle_pct = 34;
      recv_idle_pct = 62;
      write_csr(REG_SIZE, 11'd16);
      write_csr(REG_LIMIT, 10'd3);
      send_item(CMD_CLEAR, 64'h0, 32'h0);
      random_phase(380, 40);
      drain();

      send_idle_pct = 62;
      recv_idle_pct = 34;
      write_csr(REG_SIZE, 11'd64);
      write_csr(REG_LIMIT, 10'd10);
      random_phase(380, 150);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(REG_SIZE, 11'd1024);
      write_csr(REG_LIMIT, 10'd96);
      random_phase(200, 2000);
      drain();
      write_csr(REG_SIZE, 11'd3);
      write_csr(REG_LIMIT, 10'd1);
      random_phase(120, 12);
      drain();

      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("linear_probe_hash_map verification clean");
      else
         $display("linear_probe_hash_map verification failed");
      $finish;
   end
endmodule
